[hw/rtl/one_wire_bus_master_unit_macros.svh]
// ----------------------------------------------------------------------------
// One-wire bus master assertion macros
// Clocked assertion helpers used by the one-wire master top level.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_UNIT_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_MACROS_SVH

// checked only outside reset
`define OWBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define OWBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/owbm_pkg.sv]
// ----------------------------------------------------------------------------
// One-wire bus master package
// Shared widths, command, phase and register codes, and bundle types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package owbm_pkg;

    localparam int CFG_BITS     = 16;
    localparam int BYTE_BITS    = 8;
    localparam int BIT_IDX_BITS = 3;
    localparam int PHASE_BITS   = 4;
    localparam int CMD_BITS     = 2;
    localparam int REG_IDX_BITS = 3;

    typedef logic [CMD_BITS-1:0]     t_cmd;
    typedef logic [PHASE_BITS-1:0]   t_phase;
    typedef logic [REG_IDX_BITS-1:0] t_reg_idx;
    typedef logic [CFG_BITS-1:0]     t_len;

    // commands
    localparam t_cmd CMD_NONE  = 2'd0;
    localparam t_cmd CMD_RESET = 2'd1;
    localparam t_cmd CMD_WRITE = 2'd2;
    localparam t_cmd CMD_READ  = 2'd3;

    // sequencer phases
    localparam t_phase PH_IDLE     = 4'd0;
    localparam t_phase PH_RST_LOW  = 4'd1;
    localparam t_phase PH_RST_WAIT = 4'd2;
    localparam t_phase PH_RST_TAIL = 4'd3;
    localparam t_phase PH_WR_LOW   = 4'd4;
    localparam t_phase PH_WR_REL   = 4'd5;
    localparam t_phase PH_RD_LOW   = 4'd6;
    localparam t_phase PH_RD_WAIT  = 4'd7;
    localparam t_phase PH_RD_REST  = 4'd8;

    // register map
    localparam t_reg_idx REG_RESET_LOW     = 3'd0;
    localparam t_reg_idx REG_PRESENCE_WAIT = 3'd1;
    localparam t_reg_idx REG_RESET_TAIL    = 3'd2;
    localparam t_reg_idx REG_SHORT_LOW     = 3'd3;
    localparam t_reg_idx REG_SLOT          = 3'd4;
    localparam t_reg_idx REG_READ_SAMPLE   = 3'd5;

    localparam t_len DEF_RESET_LOW     = 16'd480;
    localparam t_len DEF_PRESENCE_WAIT = 16'd80;
    localparam t_len DEF_RESET_TAIL    = 16'd400;
    localparam t_len DEF_SHORT_LOW     = 16'd1;
    localparam t_len DEF_SLOT          = 16'd60;
    localparam t_len DEF_READ_SAMPLE   = 16'd0;

    // release time after a written zero
    localparam t_len RECOVERY_TICKS = 16'd1;

    typedef struct packed {
        t_len reset_low;
        t_len presence_wait;
        t_len reset_tail;
        t_len short_low;
        t_len slot;
        t_len read_sample;
    } t_cfg;

    typedef struct packed {
        t_phase                  phase;
        logic [BIT_IDX_BITS-1:0] bit_idx;
        logic [BYTE_BITS-1:0]    shift;
        logic                    presence;
        logic [BYTE_BITS-1:0]    last_read;
    } t_state;

    typedef struct packed {
        logic                 drive_low;
        logic                 busy_res;
        logic                 done_res;
        logic                 presence;
        logic [BYTE_BITS-1:0] read_data;
    } t_result;

endpackage

[hw/rtl/owbm_if.sv]
// ----------------------------------------------------------------------------
// One-wire bus master channel interfaces
// Tick input, result output and register write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface owbm_in_if;
    import owbm_pkg::*;
    logic                 valid;
    logic                 ready;
    t_cmd                 command;
    logic [BYTE_BITS-1:0] write_data;
    logic                 line_level;
    modport source (output valid, command, write_data, line_level, input ready);
    modport sink   (input valid, command, write_data, line_level, output ready);
endinterface

interface owbm_out_if;
    import owbm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 drive_low;
    logic                 busy_res;
    logic                 done_res;
    logic                 presence;
    logic [BYTE_BITS-1:0] read_data;
    modport source (output valid, drive_low, busy_res, done_res, presence, read_data,
                    input ready);
    modport sink   (input valid, drive_low, busy_res, done_res, presence, read_data,
                    output ready);
endinterface

interface owbm_cfg_if;
    import owbm_pkg::*;
    logic     valid;
    logic     ready;
    t_reg_idx index;
    t_len     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/one_wire_bus_master_unit.sv]
// ----------------------------------------------------------------------------
// One-wire bus master unit
// Open-drain single-wire bus master stepped once per bus tick.
//   i_in  : one word per bus tick - command (none, reset, write, read),
//           write byte and the sampled line level.
//   o_out : one word per accepted tick - line drive, busy, done, presence
//           flag and the byte from the last completed read.
//   i_cfg : register writes (index, 16-bit data), always ready; the user must
//           write only while the unit is idle, the block does not enforce it.
// The result word is loaded into the output register when the tick is
// accepted. Throughput: one tick per cycle while o_out is not stalled, set by
// the state registers and the single output register, both loaded on acceptance.
// Commands arriving while a command runs are ignored.
// Reset: timing registers return to their defaults, the sequencer goes
// idle with presence and read byte cleared, the output register empties.
// Stall: while a result waits with o_out.ready low, i_in.ready is low and
// the sequencer holds; the word is taken and a new tick enters together.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "one_wire_bus_master_unit_macros.svh"

module one_wire_bus_master_unit #(
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    owbm_in_if.sink     i_in,
    owbm_out_if.source  o_out,
    owbm_cfg_if.sink    i_cfg
);
    import owbm_pkg::*;

    // timing registers
    t_cfg cfg;

    owbm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // sequencer state
    t_state                r_state;
    t_state                n_state;
    logic [TIMER_BITS-1:0] r_timer;
    logic [TIMER_BITS-1:0] n_timer;

    // output register
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic in_take;

    // room when empty or when the held word leaves this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_take    = i_in.valid && i_in.ready;

    owbm_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_cfg        (cfg),
        .i_state      (r_state),
        .i_timer      (r_timer),
        .i_command    (i_in.command),
        .i_write_data (i_in.write_data),
        .i_line_level (i_in.line_level),
        .o_state      (n_state),
        .o_timer      (n_timer),
        .o_result     (n_out)
    );

    // state moves only on an accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= PH_IDLE;
            r_state.bit_idx   <= '0;
            r_state.shift     <= '0;
            r_state.presence  <= 1'b0;
            r_state.last_read <= '0;
            r_timer           <= '0;
        end else if (in_take) begin
            r_state <= n_state;
            r_timer <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.drive_low = r_out.drive_low;
    assign o_out.busy_res  = r_out.busy_res;
    assign o_out.done_res  = r_out.done_res;
    assign o_out.presence  = r_out.presence;
    assign o_out.read_data = r_out.read_data;

    // a stalled result word blocks the input
    `OWBM_ASSERT(a_stall_blocks_in, (o_out.valid && !o_out.ready) |-> !i_in.ready, "input taken while result stalled")

    // an idle tick with no command gives a quiet, not-busy result
    `OWBM_ASSERT(a_idle_quiet, (in_take && r_state.phase == PH_IDLE && i_in.command == CMD_NONE) |=> (o_out.valid && !o_out.busy_res && !o_out.drive_low && !o_out.done_res), "idle tick gave activity")

    // idle always leaves timer and bit counter cleared
    `OWBM_ASSERT_ALWAYS(a_idle_clean, (i_rst_n && $past(i_rst_n) && r_state.phase == PH_IDLE) |-> (r_timer == '0 && r_state.bit_idx == '0), "idle with stale timer or bit count")

endmodule

[hw/rtl/owbm_cfg.sv]
// ----------------------------------------------------------------------------
// One-wire bus master register file
// Six timing registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owbm_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    owbm_cfg_if.sink      i_cfg,
    output owbm_pkg::t_cfg o_cfg
);
    import owbm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_RESET_LOW:     n_cfg.reset_low     = i_cfg.data;
                REG_PRESENCE_WAIT: n_cfg.presence_wait = i_cfg.data;
                REG_RESET_TAIL:    n_cfg.reset_tail    = i_cfg.data;
                REG_SHORT_LOW:     n_cfg.short_low     = i_cfg.data;
                REG_SLOT:          n_cfg.slot          = i_cfg.data;
                REG_READ_SAMPLE:   n_cfg.read_sample   = i_cfg.data;
                default:           n_cfg               = r_cfg; // unmapped index
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= DEF_RESET_LOW;
            r_cfg.presence_wait <= DEF_PRESENCE_WAIT;
            r_cfg.reset_tail    <= DEF_RESET_TAIL;
            r_cfg.short_low     <= DEF_SHORT_LOW;
            r_cfg.slot          <= DEF_SLOT;
            r_cfg.read_sample   <= DEF_READ_SAMPLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[hw/rtl/owbm_seq.sv]
// ----------------------------------------------------------------------------
// One-wire bus master tick sequencer
// Next phase, timer, shift byte and result for one bus tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owbm_seq #(
    parameter int TIMER_BITS = 16
) (
    input  owbm_pkg::t_cfg                   i_cfg,
    input  owbm_pkg::t_state                 i_state,
    input  logic [TIMER_BITS-1:0]            i_timer,
    input  owbm_pkg::t_cmd                   i_command,
    input  logic [owbm_pkg::BYTE_BITS-1:0]   i_write_data,
    input  logic                             i_line_level,
    output owbm_pkg::t_state                 o_state,
    output logic [TIMER_BITS-1:0]            o_timer,
    output owbm_pkg::t_result                o_result
);
    import owbm_pkg::*;

    localparam logic [63:0] TMAX_W = (64'd1 << TIMER_BITS) - 64'd1;
    localparam logic [TIMER_BITS-1:0] TMAX = TMAX_W[TIMER_BITS-1:0];

    // length limited to what the timer can reach
    function automatic logic [TIMER_BITS-1:0] clip(input t_len len);
        logic [63:0] l;
        l = 64'(len);
        if (l > TMAX_W) begin
            return TMAX;
        end
        return l[TIMER_BITS-1:0];
    endfunction

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
        return (t == TMAX) ? t : t + 1'b1;
    endfunction

    t_state                st;
    logic [TIMER_BITS-1:0] tm;
    logic                  fin;
    logic                  cur_bit;
    t_result               res;

    always_comb begin
        st      = i_state;
        tm      = i_timer;
        fin     = 1'b0;
        res     = '0;
        cur_bit = 1'b0;

        if (st.phase == PH_IDLE && i_command != CMD_NONE) begin
            tm         = '0;
            st.bit_idx = '0;
            if (i_command == CMD_RESET) begin
                st.phase = PH_RST_LOW;
            end else if (i_command == CMD_WRITE) begin
                st.phase = PH_WR_LOW;
                st.shift = i_write_data;
            end else begin
                st.phase = PH_RD_LOW;
                st.shift = '0;
            end
        end

        if (st.phase != PH_IDLE) begin
            cur_bit      = st.shift[0];
            res.busy_res = 1'b1;
            unique case (st.phase)
                PH_RST_LOW: begin
                    res.drive_low = 1'b1;
                    tm = sat_inc(tm);
                    if (tm >= clip(i_cfg.reset_low)) begin
                        st.phase = PH_RST_WAIT;
                        tm       = '0;
                    end
                end
                PH_RST_WAIT: begin
                    if (tm >= clip(i_cfg.presence_wait)) begin
                        st.presence = ~i_line_level;
                        tm          = '0;
                        if (i_cfg.reset_tail == '0) begin
                            fin = 1'b1;
                        end else begin
                            st.phase = PH_RST_TAIL;
                        end
                    end else begin
                        tm = tm + 1'b1;
                    end
                end
                PH_RST_TAIL: begin
                    tm = sat_inc(tm);
                    if (tm >= clip(i_cfg.reset_tail)) begin
                        fin = 1'b1;
                    end
                end
                PH_WR_LOW: begin
                    res.drive_low = 1'b1;
                    tm = sat_inc(tm);
                    if (tm >= clip(cur_bit ? i_cfg.short_low : i_cfg.slot)) begin
                        st.phase = PH_WR_REL;
                        tm       = '0;
                    end
                end
                PH_WR_REL: begin
                    tm = sat_inc(tm);
                    if (tm >= clip(cur_bit ? i_cfg.slot : RECOVERY_TICKS)) begin
                        st.shift = {1'b0, st.shift[BYTE_BITS-1:1]};
                        tm       = '0;
                        if (st.bit_idx == '1) begin
                            fin = 1'b1;
                        end else begin
                            st.phase = PH_WR_LOW;
                        end
                        st.bit_idx = st.bit_idx + 1'b1;
                    end
                end
                PH_RD_LOW: begin
                    res.drive_low = 1'b1;
                    tm = sat_inc(tm);
                    if (tm >= clip(i_cfg.short_low)) begin
                        st.phase = PH_RD_WAIT;
                        tm       = '0;
                    end
                end
                PH_RD_WAIT: begin
                    if (tm >= clip(i_cfg.read_sample)) begin
                        st.shift = {i_line_level, st.shift[BYTE_BITS-1:1]};
                        st.phase = PH_RD_REST;
                        tm       = '0;
                    end else begin
                        tm = tm + 1'b1;
                    end
                end
                PH_RD_REST: begin
                    tm = sat_inc(tm);
                    if (tm >= clip(i_cfg.slot)) begin
                        tm = '0;
                        if (st.bit_idx == '1) begin
                            st.last_read = st.shift;
                            fin          = 1'b1;
                        end else begin
                            st.phase = PH_RD_LOW;
                        end
                        st.bit_idx = st.bit_idx + 1'b1;
                    end
                end
                default: begin
                    st.phase = PH_IDLE;
                    tm       = '0;
                end
            endcase
            if (fin) begin
                res.done_res = 1'b1;
                st.phase     = PH_IDLE;
                tm           = '0;
            end
        end

        res.presence  = st.presence;
        res.read_data = st.last_read;
    end

    assign o_state  = st;
    assign o_timer  = tm;
    assign o_result = res;

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// One-wire bus master unit testbench
// Drives bus ticks with commands and line levels through the valid/ready
// channels and checks every result word against a tick-exact mirror of
// the sequencer. Timing registers start at their defaults, then are
// reprogrammed between phases, from all zero lengths to short random
// lengths, with random idling on both sides until the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import owbm_pkg::*;

    localparam int TICK_BITS = 16;

    // ------------------------------------------------------------------------
    // Mirror of the sequencer: one expected word per accepted tick.
    // ------------------------------------------------------------------------
    class bus_master_mirror;
        t_cfg                    regs;
        t_phase                  phase;
        logic [TICK_BITS-1:0]    timer;
        logic [BIT_IDX_BITS-1:0] bit_idx;
        logic [BYTE_BITS-1:0]    shift;
        logic                    presence;
        logic [BYTE_BITS-1:0]    last_read;
        t_result                 words_due[$];
        int                      faults;

        function new();
            regs.reset_low     = DEF_RESET_LOW;
            regs.presence_wait = DEF_PRESENCE_WAIT;
            regs.reset_tail    = DEF_RESET_TAIL;
            regs.short_low     = DEF_SHORT_LOW;
            regs.slot          = DEF_SLOT;
            regs.read_sample   = DEF_READ_SAMPLE;
            phase     = PH_IDLE;
            timer     = '0;
            bit_idx   = '0;
            shift     = '0;
            presence  = 1'b0;
            last_read = '0;
            faults    = 0;
        endfunction

        function void set_reg(t_reg_idx idx, t_len value);
            case (idx)
                REG_RESET_LOW:     regs.reset_low     = value;
                REG_PRESENCE_WAIT: regs.presence_wait = value;
                REG_RESET_TAIL:    regs.reset_tail    = value;
                REG_SHORT_LOW:     regs.short_low     = value;
                REG_SLOT:          regs.slot          = value;
                REG_READ_SAMPLE:   regs.read_sample   = value;
                default: ;
            endcase
        endfunction

        function bit is_idle();
            return phase == PH_IDLE;
        endfunction

        function int pending();
            return words_due.size();
        endfunction

        // saturating count; true once the phase of length len is over
        function bit tick_up(t_len len);
            if (timer != '1)
                timer = timer + 1'b1;
            return timer >= len;
        endfunction

        // true when the byte is complete
        function bit bit_step();
            timer   = '0;
            bit_idx = bit_idx + 1'b1;
            return bit_idx == '0;
        endfunction

        function void take_tick(t_cmd cmd, logic [BYTE_BITS-1:0] wdata, logic line);
            t_result w;
            logic    fin;
            logic    lsb;
            w   = '0;
            fin = 1'b0;
            if (phase == PH_IDLE && cmd != CMD_NONE) begin
                timer   = '0;
                bit_idx = '0;
                case (cmd)
                    CMD_RESET: phase = PH_RST_LOW;
                    CMD_WRITE: begin
                        phase = PH_WR_LOW;
                        shift = wdata;
                    end
                    default: begin
                        phase = PH_RD_LOW;
                        shift = '0;
                    end
                endcase
            end
            if (phase != PH_IDLE) begin
                lsb        = shift[0];
                w.busy_res = 1'b1;
                case (phase)
                    PH_RST_LOW: begin
                        w.drive_low = 1'b1;
                        if (tick_up(regs.reset_low)) begin
                            phase = PH_RST_WAIT;
                            timer = '0;
                        end
                    end
                    PH_RST_WAIT: begin
                        if (timer >= regs.presence_wait) begin
                            presence = ~line;
                            timer    = '0;
                            if (regs.reset_tail == '0)
                                fin = 1'b1;
                            else
                                phase = PH_RST_TAIL;
                        end else begin
                            timer = timer + 1'b1;
                        end
                    end
                    PH_RST_TAIL: begin
                        if (tick_up(regs.reset_tail))
                            fin = 1'b1;
                    end
                    PH_WR_LOW: begin
                        w.drive_low = 1'b1;
                        if (tick_up(lsb ? regs.short_low : regs.slot)) begin
                            phase = PH_WR_REL;
                            timer = '0;
                        end
                    end
                    PH_WR_REL: begin
                        if (tick_up(lsb ? regs.slot : RECOVERY_TICKS)) begin
                            shift = shift >> 1;
                            if (bit_step())
                                fin = 1'b1;
                            else
                                phase = PH_WR_LOW;
                        end
                    end
                    PH_RD_LOW: begin
                        w.drive_low = 1'b1;
                        if (tick_up(regs.short_low)) begin
                            phase = PH_RD_WAIT;
                            timer = '0;
                        end
                    end
                    PH_RD_WAIT: begin
                        if (timer >= regs.read_sample) begin
                            shift = {line, shift[BYTE_BITS-1:1]};
                            phase = PH_RD_REST;
                            timer = '0;
                        end else begin
                            timer = timer + 1'b1;
                        end
                    end
                    PH_RD_REST: begin
                        if (tick_up(regs.slot)) begin
                            if (bit_step()) begin
                                last_read = shift;
                                fin       = 1'b1;
                            end else begin
                                phase = PH_RD_LOW;
                            end
                        end
                    end
                    default: begin
                        phase = PH_IDLE;
                        timer = '0;
                    end
                endcase
                if (fin) begin
                    w.done_res = 1'b1;
                    phase      = PH_IDLE;
                    timer      = '0;
                end
            end
            w.presence  = presence;
            w.read_data = last_read;
            words_due.push_back(w);
        endfunction

        function void field_diff(string tag, logic [BYTE_BITS-1:0] want,
                                 logic [BYTE_BITS-1:0] seen);
            if (want !== seen) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, tag, want, seen);
                faults++;
            end
        endfunction

        function void compare_word(t_result got);
            t_result want;
            if (words_due.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %0h", $time, got);
                faults++;
                return;
            end
            want = words_due.pop_front();
            field_diff("drive_low", want.drive_low, got.drive_low);
            field_diff("busy_res",  want.busy_res,  got.busy_res);
            field_diff("done_res",  want.done_res,  got.done_res);
            field_diff("presence",  want.presence,  got.presence);
            field_diff("read_data", want.read_data, got.read_data);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   lazy;     // random idling on both sides
    int   hold;     // cycles left in the current ready or not-ready burst

    bus_master_mirror mirror = new();

    owbm_in_if  in_ch();
    owbm_out_if out_ch();
    owbm_cfg_if cfg_ch();

    one_wire_bus_master_unit #(
        .TIMER_BITS (TICK_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Receiver: ready in random bursts, held high once idling is switched off.
    always @(negedge i_clk) begin
        if (!lazy) begin
            out_ch.ready = 1'b1;
        end else if (hold > 0) begin
            hold--;
        end else if ($urandom_range(0, 2) == 0) begin
            out_ch.ready = 1'b0;
            hold = $urandom_range(0, 8);
        end else begin
            out_ch.ready = 1'b1;
            hold = $urandom_range(0, 15);
        end
    end

    // Every word taken from the unit is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.drive_low = out_ch.drive_low;
            got.busy_res  = out_ch.busy_res;
            got.done_res  = out_ch.done_res;
            got.presence  = out_ch.presence;
            got.read_data = out_ch.read_data;
            mirror.compare_word(got);
        end
    end

    // One bus tick, with an optional gap before it. The mirror steps at the
    // edge the tick is taken, so the caller sees the updated phase after.
    task automatic send_tick(t_cmd cmd, logic [BYTE_BITS-1:0] wdata, logic line);
        if (lazy && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid      = 1'b1;
        in_ch.command    = cmd;
        in_ch.write_data = wdata;
        in_ch.line_level = line;
        do @(posedge i_clk); while (!in_ch.ready);
        mirror.take_tick(cmd, wdata, line);
    endtask

    // Start a command and tick until it is over; noisy ticks carry
    // random commands that the busy unit has to ignore.
    task automatic run_command(t_cmd cmd, logic [BYTE_BITS-1:0] wdata, logic line, bit noisy);
        send_tick(cmd, wdata, line);
        while (!mirror.is_idle())
            send_tick(noisy ? t_cmd'($urandom_range(0, 3)) : CMD_NONE,
                      BYTE_BITS'($urandom), line);
    endtask

    // Registers change only with the unit idle and every word delivered.
    task automatic write_reg(t_reg_idx idx, t_len value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        mirror.set_reg(idx, value);
    endtask

    task automatic load_regs(t_len rst_low, t_len pres_wait, t_len rst_tail,
                             t_len short_low, t_len slot, t_len rd_sample);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        write_reg(REG_RESET_LOW,     rst_low);
        write_reg(REG_PRESENCE_WAIT, pres_wait);
        write_reg(REG_RESET_TAIL,    rst_tail);
        write_reg(REG_SHORT_LOW,     short_low);
        write_reg(REG_SLOT,          slot);
        write_reg(REG_READ_SAMPLE,   rd_sample);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Mostly tiny lengths, now and then a slightly longer one.
    function automatic t_len pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return t_len'($urandom_range(0, 3));
        return t_len'($urandom_range(4, 12));
    endfunction

    // Idle ticks mostly start a command; busy ticks carry the odd stray one.
    task automatic random_tick();
        t_cmd cmd;
        if (mirror.is_idle())
            cmd = ($urandom_range(0, 4) != 0) ? t_cmd'($urandom_range(1, 3)) : CMD_NONE;
        else
            cmd = ($urandom_range(0, 9) == 0) ? t_cmd'($urandom_range(0, 3)) : CMD_NONE;
        send_tick(cmd, BYTE_BITS'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Random traffic under fresh timings, then run out the last command.
    task automatic random_round(int ticks);
        load_regs(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
        repeat (ticks) random_tick();
        while (!mirror.is_idle())
            send_tick(CMD_NONE, BYTE_BITS'($urandom), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        lazy             = 1'b1;
        hold             = 0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.command    = CMD_NONE;
        in_ch.write_data = '0;
        in_ch.line_level = 1'b1;
        out_ch.ready     = 1'b1;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_RESET_LOW;
        cfg_ch.data      = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: one byte at the default slot timing, mixed ones
        // and zeros, with stray commands that must be ignored
        run_command(CMD_WRITE, 8'h5A, 1'b1, 1'b1);

        // zero lengths all round: every low, slot and wait collapses to
        // one tick, and a zero tail ends the reset on its sample tick
        load_regs('0, '0, '0, '0, '0, '0);
        run_command(CMD_RESET, 8'h00, 1'b0, 1'b0);
        run_command(CMD_RESET, 8'hFF, 1'b1, 1'b0);
        run_command(CMD_WRITE, 8'h00, 1'b1, 1'b0);
        run_command(CMD_WRITE, 8'hFF, 1'b0, 1'b1);
        run_command(CMD_READ,  8'hFF, 1'b0, 1'b0);
        run_command(CMD_READ,  8'h00, 1'b1, 1'b1);
        send_tick(CMD_NONE, 8'h5A, 1'b1);

        // short timings, random traffic over several settings
        repeat (3) random_round(20);

        // last part: no idling on either side, words back to back
        lazy = 1'b0;
        random_round(30);
        @(negedge i_clk);
        in_ch.valid = 1'b0;

        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mirror.faults == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // run guard, several times the slowest expected run
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/owbm_pkg.sv
hw/rtl/owbm_if.sv
hw/rtl/owbm_cfg.sv
hw/rtl/owbm_seq.sv
hw/rtl/one_wire_bus_master_unit.sv
dv/testbench.sv
